### rtl/fcf_pkg.sv
// Shared constants and controller/datapath interface types for the FIR filter.
// Used by fcf_ctrl, fcf_datapath and fir_convolution_filter; no dependencies.
package fcf_pkg;

   localparam int MAX_TAPS  = 512;
   localparam int PTR_W     = $clog2(MAX_TAPS);
   localparam int FILL_W    = $clog2(MAX_TAPS + 1);
   localparam int TAP_W     = 10;
   localparam int IDX_W     = 9;
   localparam int DATA_W    = 24;
   localparam int FRAC_BITS = 23;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + PTR_W;
   localparam int REQ_W     = 40;

   localparam logic [TAP_W-1:0] TAP_COUNT_RESET = TAP_W'(427);

   localparam logic MODE_LOAD_COEF = 1'b0;
   localparam logic MODE_SAMPLE    = 1'b1;

   typedef struct packed {
      logic             load_coef;
      logic             load_sample;
      logic             issue;
      logic [PTR_W-1:0] tap_idx;
      logic             finalize;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/fcf_ctrl.sv
// Sequencer for the FIR filter: input handshake, tap counter and result timing.
// Depends on fcf_pkg for constants and the command/status types.
module fcf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_mode,
   input  logic                      csr_wr_en,
   input  logic [fcf_pkg::TAP_W-1:0] csr_wr_data,
   input  fcf_pkg::dp_status_type    status,
   output fcf_pkg::ctrl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [fcf_pkg::TAP_W-1:0]   tap_count_ff, tap_count_in;
   logic [fcf_pkg::TAP_W-1:0]   taps_ff, taps_in;
   logic [fcf_pkg::PTR_W-1:0]   k_ff, k_in;
   logic [fcf_pkg::TAP_W-1:0]   taps_limited;
   logic                        accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Tap counts above the history depth use the whole history.
   assign taps_limited = (tap_count_ff > fcf_pkg::TAP_W'(fcf_pkg::MAX_TAPS)) ?
                         fcf_pkg::TAP_W'(fcf_pkg::MAX_TAPS) : tap_count_ff;

   assign tap_count_in = csr_wr_en ? csr_wr_data : tap_count_ff;

   always_comb begin
      state_in = state_ff;
      taps_in  = taps_ff;
      k_in     = k_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == fcf_pkg::MODE_LOAD_COEF) begin
                  cmd.load_coef = 1'b1;
               end else begin
                  cmd.load_sample = 1'b1;
                  taps_in         = taps_limited;
                  k_in            = '0;
                  state_in        = (taps_limited == '0) ? ST_DRAIN : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue   = 1'b1;
            cmd.tap_idx = k_ff;
            k_in        = k_ff + 1'b1;
            if ({1'b0, k_ff} == taps_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               cmd.finalize = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= fcf_pkg::TAP_COUNT_RESET;
         taps_ff      <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         taps_ff      <= taps_in;
         k_ff         <= k_in;
      end
   end

endmodule

### rtl/fcf_datapath.sv
// Datapath of the FIR filter: coefficient and history memories, multiplier,
// accumulator, scaling with saturation and the result register. Uses fcf_pkg.
module fcf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  fcf_pkg::ctrl_cmd_type      cmd,
   output fcf_pkg::dp_status_type     status,
   input  logic [fcf_pkg::IDX_W-1:0]  coef_index,
   input  logic [fcf_pkg::DATA_W-1:0] data_value,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [fcf_pkg::DATA_W-1:0] filtered_sample,
   output logic                       saturated
);

   logic [fcf_pkg::DATA_W-1:0] coef_mem [fcf_pkg::MAX_TAPS];
   logic [fcf_pkg::DATA_W-1:0] hist_mem [fcf_pkg::MAX_TAPS];

   logic [fcf_pkg::PTR_W-1:0]  wptr_ff, wptr_in;
   logic [fcf_pkg::PTR_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [fcf_pkg::FILL_W-1:0] fill_ff, fill_in;

   logic [fcf_pkg::DATA_W-1:0] coef_rd_ff, hist_rd_ff;
   logic                       s1_valid_ff, s1_live_ff;
   logic                       s1_live_in;
   logic signed [fcf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                       s2_valid_ff;
   logic signed [fcf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [fcf_pkg::DATA_W-1:0] hist_op;

   logic signed [fcf_pkg::ACC_W-1:0]  shifted;
   logic                       pos_ovf, neg_ovf;
   logic [fcf_pkg::DATA_W-1:0] result_in;

   logic                       out_valid_ff, out_valid_in;
   logic [fcf_pkg::DATA_W-1:0] out_data_ff;
   logic                       out_sat_ff;

   // Memories: coefficients written on loads, history written on samples.
   always_ff @(posedge clock) begin
      if (cmd.load_coef && ({1'b0, coef_index} < (fcf_pkg::IDX_W + 1)'(fcf_pkg::MAX_TAPS))) begin
         coef_mem[coef_index] <= data_value;
      end
      coef_rd_ff <= coef_mem[cmd.tap_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         hist_mem[wptr_ff] <= data_value;
      end
      hist_rd_ff <= hist_mem[rd_pos_ff];
   end

   // A history slot that was never written since reset reads as zero, which
   // the fill count tracks because slots are written strictly in order.
   always_comb begin
      wptr_in   = wptr_ff;
      rd_pos_in = rd_pos_ff;
      fill_in   = fill_ff;
      if (cmd.load_sample) begin
         rd_pos_in = wptr_ff;
         wptr_in   = (wptr_ff == fcf_pkg::PTR_W'(fcf_pkg::MAX_TAPS - 1)) ?
                     '0 : wptr_ff + 1'b1;
         if (fill_ff != fcf_pkg::FILL_W'(fcf_pkg::MAX_TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.issue) begin
         rd_pos_in = (rd_pos_ff == '0) ?
                     fcf_pkg::PTR_W'(fcf_pkg::MAX_TAPS - 1) : rd_pos_ff - 1'b1;
      end
   end

   assign s1_live_in = ({1'b0, cmd.tap_idx} < fcf_pkg::FILL_W'(fill_ff));
   assign hist_op    = s1_live_ff ? hist_rd_ff : '0;
   assign prod_in    = $signed(coef_rd_ff) * hist_op;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_sample) begin
         acc_in = '0;
      end else if (s2_valid_ff) begin
         acc_in = acc_ff + {{(fcf_pkg::ACC_W - fcf_pkg::PROD_W){prod_ff[fcf_pkg::PROD_W-1]}},
                            prod_ff};
      end
   end

   // Arithmetic shift rounds toward minus infinity; then clip to 24 bits.
   assign shifted = acc_ff >>> fcf_pkg::FRAC_BITS;
   assign pos_ovf = !shifted[fcf_pkg::ACC_W-1] &&
                    (|shifted[fcf_pkg::ACC_W-2:fcf_pkg::DATA_W-1]);
   assign neg_ovf = shifted[fcf_pkg::ACC_W-1] &&
                    !(&shifted[fcf_pkg::ACC_W-2:fcf_pkg::DATA_W-1]);

   always_comb begin
      priority if (pos_ovf) begin
         result_in = {1'b0, {(fcf_pkg::DATA_W - 1){1'b1}}};
      end else if (neg_ovf) begin
         result_in = {1'b1, {(fcf_pkg::DATA_W - 1){1'b0}}};
      end else begin
         result_in = shifted[fcf_pkg::DATA_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finalize) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rd_pos_ff    <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wptr_ff      <= wptr_in;
         rd_pos_ff    <= rd_pos_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff <= s1_live_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      if (cmd.finalize) begin
         out_data_ff <= result_in;
         out_sat_ff  <= pos_ovf || neg_ovf;
      end
   end

   assign status.pipe_busy = s1_valid_ff || s2_valid_ff;
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid      = out_valid_ff;
   assign filtered_sample = out_data_ff;
   assign saturated       = out_sat_ff;

endmodule

### rtl/fir_convolution_filter.sv
// Top level of the direct-form FIR filter: joins the sequencer and datapath.
// Depends on fcf_pkg, fcf_ctrl and fcf_datapath.
//
//   Channel | Direction | Contents
//   req_*   | in        | tuser: mode; tdata: coef_index [8:0], data_value [32:9]
//   rsp_*   | out       | tdata: filtered_sample [23:0]; tuser: saturated
//   csr_*   | in        | tap_count, written whenever csr_wr_en is high
//
// A coefficient load is written straight from its input transfer. A sample is run
// as one multiply-accumulate per tap (none when the tap count is zero) through the
// single read port of each memory and the three-stage MAC pipeline into the result
// register; the next input transfer is taken only after that write.
// Reset is synchronous; history reads as zero after reset with no clearing pass.
// A result waiting on rsp_tready does not block the next input transfer, but
// the next result waits until the result register is free.
module fir_convolution_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fcf_pkg::REQ_W-1:0]   req_tdata,   // coef_index, data_value
   input  logic                        req_tuser,   // mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fcf_pkg::DATA_W-1:0]  rsp_tdata,   // filtered_sample
   output logic                        rsp_tuser,   // saturated
   input  logic                        csr_wr_en,
   input  logic [fcf_pkg::TAP_W-1:0]   csr_wr_data
);

   fcf_pkg::ctrl_cmd_type  cmd;
   fcf_pkg::dp_status_type status;

   logic [fcf_pkg::IDX_W-1:0]  req_coef_index;
   logic [fcf_pkg::DATA_W-1:0] req_data_value;

   assign req_coef_index = req_tdata[fcf_pkg::IDX_W-1:0];
   assign req_data_value = req_tdata[fcf_pkg::IDX_W+fcf_pkg::DATA_W-1:fcf_pkg::IDX_W];

   fcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   fcf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .coef_index      (req_coef_index),
      .data_value      (req_data_value),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .filtered_sample (rsp_tdata),
      .saturated       (rsp_tuser)
   );

`ifndef ASSERT_OFF
   // A result is never written over one that has not been transferred.
   a_finalize_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finalize |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   a_finalize_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finalize |=> rsp_tvalid)
      else $error("finished result not presented");

   // No tap is issued while the block accepts new input.
   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.issue)
      else $error("tap issued while idle");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sample |=> !req_tready)
      else $error("input accepted during convolution");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for fir_convolution_filter: coefficient loads and samples
// go in over req_*, and each filtered result on rsp_* is checked against a local
// fixed-point convolution. Depends on fcf_pkg and the filter RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [fcf_pkg::DATA_W-1:0] Q23_MAX = 24'sh7FFFFF;
   localparam logic signed [fcf_pkg::DATA_W-1:0] Q23_MIN = 24'sh800000;
   localparam longint SAT_HIGH = 64'sd8388607;
   localparam longint SAT_LOW = -64'sd8388608;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_CYCLES = 600;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 65;

   typedef struct {
      logic [fcf_pkg::DATA_W-1:0] sample;
      logic clipped;
   } filter_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [fcf_pkg::REQ_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [fcf_pkg::DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en;
   logic [fcf_pkg::TAP_W-1:0] csr_wr_data;

   // Local copy of the filter state.
   logic signed [fcf_pkg::DATA_W-1:0] hist_ring [fcf_pkg::MAX_TAPS];
   logic signed [fcf_pkg::DATA_W-1:0] coef_bank [fcf_pkg::MAX_TAPS];
   logic [fcf_pkg::PTR_W-1:0] ring_ptr;
   logic [fcf_pkg::TAP_W-1:0] tap_setting;

   filter_result_type pending_filter_results [$];
   int error_count = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit hold_request = 0;
   bit req_gaps_on = 1;
   bit rsp_gaps_on = 1;
   bit req_offer = 0;

   fir_convolution_filter uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 0;
   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Random Q1.23 value with a random magnitude, so that results span the
   // whole range instead of clipping almost every time.
   function automatic logic signed [fcf_pkg::DATA_W-1:0] random_q23();
      logic signed [fcf_pkg::DATA_W-1:0] raw;
      raw = fcf_pkg::DATA_W'($urandom);
      return raw >>> $urandom_range(0, fcf_pkg::FRAC_BITS);
   endfunction

   function automatic void predict_filter_step(input logic mode,
                                               input logic [fcf_pkg::IDX_W-1:0] idx,
                                               input logic signed [fcf_pkg::DATA_W-1:0] value);
      longint acc;
      longint quotient;
      int taps;
      int pos;
      filter_result_type result;
      if (mode == fcf_pkg::MODE_LOAD_COEF) begin
         coef_bank[idx] = value;
         return;
      end
      hist_ring[ring_ptr] = value;
      pos = int'(ring_ptr);
      ring_ptr = ring_ptr + 1'b1;
      taps = (tap_setting > fcf_pkg::MAX_TAPS) ? fcf_pkg::MAX_TAPS : int'(tap_setting);
      acc = 0;
      for (int k = 0; k < taps; k++) begin
         acc += longint'(coef_bank[k]) * longint'(hist_ring[pos]);
         pos = (pos == 0) ? fcf_pkg::MAX_TAPS - 1 : pos - 1;
      end
      // Arithmetic shift of a signed value rounds toward minus infinity.
      quotient = acc >>> fcf_pkg::FRAC_BITS;
      result.clipped = 1'b0;
      if (quotient > SAT_HIGH) begin
         quotient = SAT_HIGH;
         result.clipped = 1'b1;
      end else if (quotient < SAT_LOW) begin
         quotient = SAT_LOW;
         result.clipped = 1'b1;
      end
      result.sample = quotient[fcf_pkg::DATA_W-1:0];
      pending_filter_results.push_back(result);
   endfunction

   // Drops the request valid unless it is already low.
   task automatic stop_requests();
      if (req_offer) begin
         req_tvalid <= 1'b0;
         req_offer = 1'b0;
      end
   endtask

   // The request valid is left high after a transfer; the caller either sends the
   // next item in the same time step or calls stop_requests.
   task automatic send_request(input logic mode, input logic [fcf_pkg::IDX_W-1:0] idx,
                               input logic signed [fcf_pkg::DATA_W-1:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         stop_requests();
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_offer = 1'b1;
      req_tuser <= mode;
      req_tdata <= fcf_pkg::REQ_W'({value, idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_filter_step(mode, idx, value);
   endtask

   task automatic send_sample(input logic signed [fcf_pkg::DATA_W-1:0] value);
      send_request(fcf_pkg::MODE_SAMPLE, fcf_pkg::IDX_W'($urandom), value);
   endtask

   // A coefficient load yields no result and can still be in flight when the
   // last result arrives, hence the SETTLE_CYCLES wait.
   task automatic wait_for_idle();
      stop_requests();
      while (pending_filter_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [fcf_pkg::TAP_W-1:0] value);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tap_setting = value;
   endtask

   task automatic check_filter_output();
      filter_result_type want;
      if (pending_filter_results.size() == 0) begin
         $display("%0t: unexpected result, actual sample %h saturated %b",
                  $time, rsp_tdata, rsp_tuser);
         error_count++;
      end else begin
         want = pending_filter_results.pop_front();
         if (rsp_tdata !== want.sample) begin
            $display("%0t: filtered_sample mismatch, expected %h, actual %h",
                     $time, want.sample, rsp_tdata);
            error_count++;
         end
         if (rsp_tuser !== want.clipped) begin
            $display("%0t: saturated mismatch, expected %b, actual %b",
                     $time, want.clipped, rsp_tuser);
            error_count++;
         end
      end
   endtask

   // Result side: checks each transfer and draws the stall before the next one.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         check_filter_output();
         stall_left = rsp_gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (hold_request) begin
         stall_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (reset || stall_left > 0) begin
         rsp_tready <= 1'b0;
         if (!reset) stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Loads every coefficient, then filters at the tap count left by reset.
   task automatic test_reset_tap_count();
      for (int i = 0; i < fcf_pkg::MAX_TAPS; i++)
         send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'(i), random_q23());
      for (int i = 0; i < 6; i++)
         send_sample(random_q23());
      stop_requests();
   endtask

   task automatic test_sample_extremes();
      write_tap_count(fcf_pkg::TAP_W'(1));
      send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'(0), Q23_MIN);
      send_sample(Q23_MIN);   // Minus one squared clips to the top.
      send_sample(Q23_MAX);
      send_sample('0);
      send_sample(-24'sd1);
      send_sample(24'sd1);
      send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'(0), Q23_MAX);
      send_sample(-24'sd1);   // Small negative product floors to minus one LSB.
      send_sample(24'sd1);
      send_sample(Q23_MIN);
      stop_requests();
      write_tap_count(fcf_pkg::TAP_W'(2));
      send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'(0), Q23_MIN);
      send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'(1), Q23_MIN);
      send_request(fcf_pkg::MODE_LOAD_COEF, {fcf_pkg::IDX_W{1'b1}}, Q23_MAX);
      send_sample(Q23_MIN);
      send_sample(Q23_MIN);
      send_sample(Q23_MAX);
      send_sample(Q23_MAX);
      stop_requests();
      write_tap_count('0);
      send_sample(Q23_MAX);
      send_sample(Q23_MIN);
      stop_requests();
   endtask

   // Full length, and a setting above the store size that must saturate.
   task automatic test_tap_count_limits();
      write_tap_count(fcf_pkg::TAP_W'(fcf_pkg::MAX_TAPS));
      for (int i = 0; i < 4; i++)
         send_sample(random_q23());
      stop_requests();
      write_tap_count({fcf_pkg::TAP_W{1'b1}});
      for (int i = 0; i < 4; i++)
         send_sample(random_q23());
      stop_requests();
   endtask

   // The receiver holds off while samples keep coming, so the result register
   // stays full and the input must stall.
   task automatic test_output_backpressure();
      write_tap_count(fcf_pkg::TAP_W'(3));
      req_gaps_on = 0;
      hold_request = 1;
      for (int i = 0; i < 12; i++)
         send_sample(random_q23());
      stop_requests();
      req_gaps_on = 1;
   endtask

   task automatic test_random_traffic();
      logic [fcf_pkg::TAP_W-1:0] taps;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 4)
            taps = fcf_pkg::TAP_W'(fcf_pkg::MAX_TAPS);
         else if (phase == 8)
            taps = fcf_pkg::TAP_W'($urandom_range(fcf_pkg::MAX_TAPS + 1,
                                                  (1 << fcf_pkg::TAP_W) - 1));
         else
            taps = fcf_pkg::TAP_W'($urandom_range(1, 48));
         write_tap_count(taps);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15)
               send_request(fcf_pkg::MODE_LOAD_COEF, fcf_pkg::IDX_W'($urandom),
                            random_q23());
            else
               send_sample(random_q23());
         end
         stop_requests();
      end
      req_gaps_on = 1;
      rsp_gaps_on = 1;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      ring_ptr = '0;
      tap_setting = fcf_pkg::TAP_COUNT_RESET;
      for (int i = 0; i < fcf_pkg::MAX_TAPS; i++) begin
         hist_ring[i] = '0;
         coef_bank[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_tap_count();
      test_sample_extremes();
      test_tap_count_limits();
      test_output_backpressure();
      test_random_traffic();

      stop_requests();
      while (pending_filter_results.size() != 0) @(posedge clock);
      repeat (FINAL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_filter_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
